// ===== design/vn_pkg.sv =====
// ---------------------------------------------------------------------------
// vn_pkg
// Shared constants and pipeline control type for the vector normalizer.
// ---------------------------------------------------------------------------
package vn_pkg;

  // Width of each vector component port
  localparam int VEC_WIDTH = 32;

  // Default parameter values
  localparam int IN_WIDTH_DEF  = 32;
  localparam int OUT_FRAC_DEF  = 16;

  // Number of vector components
  localparam int LANES = 3;

  // Control that travels with every item down the pipeline
  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [LANES-1:0] neg;
  } vn_ctl_t;

endpackage

// ===== design/vn_square.sv =====
// ---------------------------------------------------------------------------
// vn_square
// Front end: component magnitudes, their squares, and the squared length.
// Three register stages.
// ---------------------------------------------------------------------------
module vn_square #(
  parameter int W = vn_pkg::IN_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [vn_pkg::VEC_WIDTH-1:0] vec_x,
  input  logic [vn_pkg::VEC_WIDTH-1:0] vec_y,
  input  logic [vn_pkg::VEC_WIDTH-1:0] vec_z,
  output vn_pkg::vn_ctl_t              ctl,
  output logic [2*W-1:0]               sq [vn_pkg::LANES],
  output logic [2*W-1:0]               sum_sq
);
  import vn_pkg::*;

  logic [W-1:0]       raw [LANES];
  logic [W-1:0]       mag1 [LANES];
  logic [LANES-1:0]   neg1;
  logic               v1;
  logic [2*W-1:0]     sq2 [LANES];
  logic [LANES-1:0]   neg2;
  logic               v2;
  logic [2*W-1:0]     sum_c;

  // Only the low W bits of each field carry the component
  assign raw[0] = vec_x[W-1:0];
  assign raw[1] = vec_y[W-1:0];
  assign raw[2] = vec_z[W-1:0];

  // Stage 1: sign and magnitude (most negative value fits unsigned)
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      neg1[l] <= raw[l][W-1];
      mag1[l] <= raw[l][W-1] ? ((~raw[l]) + W'(1)) : raw[l];
    end
    if (rst) v1 <= 1'b0;
    else     v1 <= in_valid;
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      sq2[l] <= mag1[l] * mag1[l];
    end
    neg2 <= neg1;
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  // Stage 3: squared length, fits 2W bits
  assign sum_c = sq2[0] + sq2[1] + sq2[2];

  always_ff @(posedge clk) begin
    sum_sq   <= sum_c;
    sq       <= sq2;
    ctl.zero <= (sum_c == '0);
    ctl.neg  <= neg2;
    if (rst) ctl.valid <= 1'b0;
    else     ctl.valid <= v2;
  end

endmodule

// ===== design/vn_divide.sv =====
// ---------------------------------------------------------------------------
// vn_divide
// Pipelined restoring divider: floor(c*c * 2^(2F) / S) for each lane,
// one quotient bit per stage, 2F+1 stages.
// ---------------------------------------------------------------------------
module vn_divide #(
  parameter int W = vn_pkg::IN_WIDTH_DEF,
  parameter int F = vn_pkg::OUT_FRAC_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  vn_pkg::vn_ctl_t ctl_in,
  input  logic [2*W-1:0]  sq_in [vn_pkg::LANES],
  input  logic [2*W-1:0]  s_in,
  output vn_pkg::vn_ctl_t ctl_out,
  output logic [2*F:0]    quo_out [vn_pkg::LANES]
);
  import vn_pkg::*;

  localparam int NS = 2*F + 1;
  localparam int SW = 2*W;
  localparam int RW = SW + 1;
  localparam int QW = 2*F + 1;

  vn_ctl_t        ctl_r [NS];
  logic [SW-1:0]  s_r [NS];
  logic [RW-1:0]  rem_r [NS][LANES];
  logic [QW-1:0]  quo_r [NS][LANES];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    vn_ctl_t       ctl_c;
    logic [SW-1:0] s_c;
    logic [RW-1:0] rem_c [LANES];
    logic [QW-1:0] quo_c [LANES];

    // Stage input: module inputs or previous stage
    if (i == 0) begin : g_first
      always_comb begin
        ctl_c = ctl_in;
        s_c   = s_in;
        for (int l = 0; l < LANES; l++) begin
          rem_c[l] = {1'b0, sq_in[l]};
          quo_c[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        ctl_c = ctl_r[i-1];
        s_c   = s_r[i-1];
        for (int l = 0; l < LANES; l++) begin
          rem_c[l] = rem_r[i-1][l];
          quo_c[l] = quo_r[i-1][l];
        end
      end
    end

    // One compare and subtract per lane
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic          ge;
      logic [RW-1:0] diff;

      assign ge   = (rem_c[l] >= {1'b0, s_c});
      assign diff = ge ? (rem_c[l] - {1'b0, s_c}) : rem_c[l];

      // Remainder stays below S, so the shift never loses a bit
      always_ff @(posedge clk) begin
        rem_r[i][l] <= {diff[RW-2:0], 1'b0};
        quo_r[i][l] <= {quo_c[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      s_r[i]        <= s_c;
      ctl_r[i].zero <= ctl_c.zero;
      ctl_r[i].neg  <= ctl_c.neg;
      if (rst) ctl_r[i].valid <= 1'b0;
      else     ctl_r[i].valid <= ctl_c.valid;
    end
  end

  assign ctl_out = ctl_r[NS-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_out[l] = quo_r[NS-1][l];
    end
  end

endmodule

// ===== design/vn_sqrt.sv =====
// ---------------------------------------------------------------------------
// vn_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// F+1 stages per lane.
// ---------------------------------------------------------------------------
module vn_sqrt #(
  parameter int F = vn_pkg::OUT_FRAC_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  vn_pkg::vn_ctl_t ctl_in,
  input  logic [2*F:0]    rad_in [vn_pkg::LANES],
  output vn_pkg::vn_ctl_t ctl_out,
  output logic [F:0]      root_out [vn_pkg::LANES]
);
  import vn_pkg::*;

  localparam int NS = F + 1;
  localparam int RW = 2*F + 1;
  localparam int TW = 2*F + 3;
  localparam int OW = F + 1;

  vn_ctl_t       ctl_r [NS];
  logic [RW-1:0] rem_r [NS][LANES];
  logic [OW-1:0] root_r [NS][LANES];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    localparam int B = F - i;

    vn_ctl_t       ctl_c;
    logic [RW-1:0] rem_c [LANES];
    logic [OW-1:0] root_c [LANES];

    if (i == 0) begin : g_first
      always_comb begin
        ctl_c = ctl_in;
        for (int l = 0; l < LANES; l++) begin
          rem_c[l]  = rad_in[l];
          root_c[l] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        ctl_c = ctl_r[i-1];
        for (int l = 0; l < LANES; l++) begin
          rem_c[l]  = rem_r[i-1][l];
          root_c[l] = root_r[i-1][l];
        end
      end
    end

    // Trial (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B); bits of q lie above B
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [TW-1:0] trial;
      logic          ge;

      assign trial = (TW'(root_c[l]) << (B + 1)) | (TW'(1) << (2*B));
      assign ge    = (trial <= TW'(rem_c[l]));

      always_ff @(posedge clk) begin
        rem_r[i][l]  <= ge ? (rem_c[l] - RW'(trial)) : rem_c[l];
        root_r[i][l] <= ge ? (root_c[l] | (OW'(1) << B)) : root_c[l];
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[i].zero <= ctl_c.zero;
      ctl_r[i].neg  <= ctl_c.neg;
      if (rst) ctl_r[i].valid <= 1'b0;
      else     ctl_r[i].valid <= ctl_c.valid;
    end
  end

  assign ctl_out = ctl_r[NS-1];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      root_out[l] = root_r[NS-1][l];
    end
  end

endmodule

// ===== design/vector3_normalize.sv =====
// ---------------------------------------------------------------------------
// vector3_normalize
// Scales a signed fixed-point 3D vector to unit length (signed Q1.F).
// ---------------------------------------------------------------------------
// Usage:
//   Drive vec_x, vec_y, vec_z and pulse start; a transfer happens on each
//   rising edge with start high and busy low. busy is high only during reset,
//   so a new vector can be taken every cycle.
//   Each result appears on unit_x, unit_y, unit_z, zero_length for exactly
//   one cycle with done high; the receiver cannot stall, none is needed.
//   The pipeline is built from these register stages:
//   3 front-end stages (magnitude, square, sum), 2*F+1 divider stages that
//   give floor(c*c*2^(2F)/S), F+1 square-root stages, and one output stage.
//   Throughput is one vector per cycle, set by the fully pipelined divider
//   and root units.
//   A zero vector gives zero components with zero_length high.
//   Reset clears all pipeline valid bits; vectors in flight are dropped.
// ---------------------------------------------------------------------------
module vector3_normalize #(
  parameter int IN_WIDTH      = vn_pkg::IN_WIDTH_DEF,
  parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [vn_pkg::VEC_WIDTH-1:0] vec_x,
  input  logic [vn_pkg::VEC_WIDTH-1:0] vec_y,
  input  logic [vn_pkg::VEC_WIDTH-1:0] vec_z,
  output logic                         done,
  output logic signed [OUT_FRAC_BITS+1:0] unit_x,
  output logic signed [OUT_FRAC_BITS+1:0] unit_y,
  output logic signed [OUT_FRAC_BITS+1:0] unit_z,
  output logic                         zero_length
);
  import vn_pkg::*;

  localparam int F  = OUT_FRAC_BITS;
  localparam int OW = F + 2;
  localparam logic signed [OW-1:0] UNIT_MAX = OW'(1) << F;

  vn_ctl_t        sq_ctl;
  logic [2*IN_WIDTH-1:0] sq [LANES];
  logic [2*IN_WIDTH-1:0] sum_sq;
  vn_ctl_t        div_ctl;
  logic [2*F:0]   quo [LANES];
  vn_ctl_t        rt_ctl;
  logic [F:0]     root [LANES];
  logic [OW-1:0]  unit_next [LANES];

  assign busy = rst;

  vn_square #(.W(IN_WIDTH)) u_square (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .vec_z    (vec_z),
    .ctl      (sq_ctl),
    .sq       (sq),
    .sum_sq   (sum_sq)
  );

  vn_divide #(.W(IN_WIDTH), .F(F)) u_divide (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (sq_ctl),
    .sq_in   (sq),
    .s_in    (sum_sq),
    .ctl_out (div_ctl),
    .quo_out (quo)
  );

  vn_sqrt #(.F(F)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (div_ctl),
    .rad_in   (quo),
    .ctl_out  (rt_ctl),
    .root_out (root)
  );

  // Sign restore; zero vector forces zeros
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (rt_ctl.zero)        unit_next[l] = '0;
      else if (rt_ctl.neg[l]) unit_next[l] = -{1'b0, root[l]};
      else                    unit_next[l] = {1'b0, root[l]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    unit_x      <= unit_next[0];
    unit_y      <= unit_next[1];
    unit_z      <= unit_next[2];
    zero_length <= rt_ctl.zero;
    if (rst) done <= 1'b0;
    else     done <= rt_ctl.valid;
  end

  // Zero vector gives all-zero components
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    done && zero_length |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
    else $error("zero vector with nonzero result");

  // Nonzero vector has at least one nonzero component
  a_nonzero_out: assert property (@(posedge clk) disable iff (rst)
    done && !zero_length |-> unit_x != '0 || unit_y != '0 || unit_z != '0)
    else $error("nonzero vector normalized to zero");

  // Every component stays within unit range
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> unit_x <= UNIT_MAX && unit_x >= -UNIT_MAX &&
             unit_y <= UNIT_MAX && unit_y >= -UNIT_MAX &&
             unit_z <= UNIT_MAX && unit_z >= -UNIT_MAX)
    else $error("unit component out of range");

endmodule
